/* rtl/core/fwss_pkg.sv */
// Shared types, codes and sizing constants of the flash write session sequencer.
package fwss_pkg;

    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_BYTES   = 256;
    localparam int MAX_SECTORS  = 128;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 24;
    localparam int CLEN_W  = 9;
    localparam int SB_W    = $clog2(SECTOR_BYTES);
    localparam int PB_W    = $clog2(PAGE_BYTES);
    localparam int HI_W    = ADDR_W - SB_W;
    localparam int IDX_W   = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam int CHUNK_W = $clog2(PAGE_BYTES + 1);

    typedef enum logic [1:0] {
        KIND_OPEN  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_RESP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FRES_OK     = 2'd0,
        FRES_FAIL   = 2'd1,
        FRES_VERIFY = 2'd2
    } t_fres;

    typedef enum logic [1:0] {
        RK_STATUS  = 2'd0,
        RK_ERASE   = 2'd1,
        RK_PROGRAM = 2'd2
    } t_rkind;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_WRONG      = 3'd1,
        STS_BOUNDS     = 3'd2,
        STS_ERASE_FAIL = 3'd3,
        STS_WRITE_FAIL = 3'd4,
        STS_VERIFY     = 3'd5,
        STS_INCOMPLETE = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        SES_CLOSED = 3'b001,
        SES_OPEN   = 3'b010,
        SES_ERROR  = 3'b100
    } t_session;

    typedef enum logic {
        CFG_REGION_BASE  = 1'b0,
        CFG_REGION_LIMIT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [1:0]        flash_result;
    } t_item;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [ADDR_W-1:0] command_address;
        logic [CLEN_W-1:0] command_length;
        logic [2:0]        status;
    } t_result;

endpackage

/* rtl/core/fwss_in_if.sv */
// Input channel interface: session commands and flash responses.
interface fwss_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [23:0] length;
    logic [1:0]  flash_result;

    modport source(output valid, output kind, output address, output length,
                   output flash_result, input ready);
    modport sink(input valid, input kind, input address, input length,
                 input flash_result, output ready);
endinterface

/* rtl/core/fwss_out_if.sv */
// Output channel interface: status reports and flash commands.
interface fwss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] command_address;
    logic [8:0]  command_length;
    logic [2:0]  status;

    modport source(output valid, output result_kind, output command_address,
                   output command_length, output status, input ready);
    modport sink(input valid, input result_kind, input command_address,
                 input command_length, input status, output ready);
endinterface

/* rtl/core/fwss_in_stage.sv */
// Input register stage: captures one item and holds it until the engine takes it.
module fwss_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fwss_in_if.sink         i_item,
    input  logic            i_advance,
    output logic            o_valid,
    output fwss_pkg::t_item o_item
);
    logic            r_valid;
    fwss_pkg::t_item r_item;
    logic            w_take;

    assign i_item.ready = !r_valid || i_advance;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind         <= i_item.kind;
            r_item.address      <= i_item.address;
            r_item.length       <= i_item.length;
            r_item.flash_result <= i_item.flash_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

/* rtl/core/fwss_engine.sv */
// Session engine: region registers, session state, sector bitmap and command issue.
module fwss_engine (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [fwss_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                      i_fire,
    input  fwss_pkg::t_item           i_item,
    output fwss_pkg::t_result         o_result
);
    logic [fwss_pkg::ADDR_W-1:0]      r_base;
    logic [fwss_pkg::ADDR_W-1:0]      r_limit;
    fwss_pkg::t_session               r_ses, n_ses;
    logic                             r_busy, n_busy;
    logic                             r_is_erase, n_is_erase;
    logic [fwss_pkg::ADDR_W-1:0]      r_next, n_next;
    logic [fwss_pkg::LEN_W-1:0]       r_left, n_left;
    logic [fwss_pkg::CHUNK_W-1:0]     r_chunk, n_chunk;
    logic                             r_written, n_written;
    logic [fwss_pkg::MAX_SECTORS-1:0] r_erased, n_erased;

    // Candidate position for the next command and the issue logic on it.
    logic [fwss_pkg::ADDR_W-1:0]  w_cand;
    logic [fwss_pkg::LEN_W-1:0]   w_cand_left;
    logic [fwss_pkg::ADDR_W-1:0]  w_next_adv;
    logic [fwss_pkg::LEN_W-1:0]   w_left_adv;
    logic [fwss_pkg::HI_W-1:0]    w_cand_hi;
    logic [fwss_pkg::HI_W-1:0]    w_base_hi;
    logic [fwss_pkg::HI_W-1:0]    w_diff_hi;
    logic [fwss_pkg::IDX_W-1:0]   w_idx;
    logic                         w_iss_fail;
    logic [fwss_pkg::CHUNK_W-1:0] w_room;
    logic [fwss_pkg::CHUNK_W-1:0] w_chunk;
    logic                         w_bad_write;
    logic                         w_do_issue;
    logic                         w_mark;
    logic                         w_sect_erased;

    assign w_next_adv = r_next + fwss_pkg::ADDR_W'(r_chunk);
    assign w_left_adv = r_left - fwss_pkg::LEN_W'(r_chunk);

    always_comb begin
        if (i_item.kind == fwss_pkg::KIND_WRITE) begin
            w_cand      = i_item.address;
            w_cand_left = i_item.length;
        end else if (r_is_erase) begin
            w_cand      = r_next;
            w_cand_left = r_left;
        end else begin
            w_cand      = w_next_adv;
            w_cand_left = w_left_adv;
        end
    end

    assign w_cand_hi  = w_cand[fwss_pkg::ADDR_W-1:fwss_pkg::SB_W];
    assign w_base_hi  = r_base[fwss_pkg::ADDR_W-1:fwss_pkg::SB_W];
    assign w_diff_hi  = w_cand_hi - w_base_hi;
    assign w_idx      = w_diff_hi[fwss_pkg::IDX_W-1:0];
    assign w_iss_fail = (w_cand_hi < w_base_hi) ||
                        (w_diff_hi >= fwss_pkg::HI_W'(fwss_pkg::MAX_SECTORS));

    // A chunk runs to the end of its page or the end of the write, whichever comes first.
    assign w_room  = fwss_pkg::CHUNK_W'(fwss_pkg::PAGE_BYTES)
                   - fwss_pkg::CHUNK_W'(w_cand[fwss_pkg::PB_W-1:0]);
    assign w_chunk = (fwss_pkg::LEN_W'(w_room) > w_cand_left)
                   ? w_cand_left[fwss_pkg::CHUNK_W-1:0] : w_room;

    assign w_bad_write = (i_item.length == '0) || (i_item.address < r_base) ||
                         (i_item.address >= r_limit) ||
                         (fwss_pkg::ADDR_W'(i_item.length) > (r_limit - i_item.address));

    always_comb begin
        n_ses      = r_ses;
        n_busy     = r_busy;
        n_is_erase = r_is_erase;
        n_next     = r_next;
        n_left     = r_left;
        n_chunk    = r_chunk;
        n_written  = r_written;
        n_erased   = r_erased;
        w_do_issue = 1'b0;
        w_mark     = 1'b0;
        o_result.result_kind     = fwss_pkg::RK_STATUS;
        o_result.command_address = '0;
        o_result.command_length  = '0;
        o_result.status          = fwss_pkg::STS_OK;

        case (i_item.kind)
            fwss_pkg::KIND_OPEN: begin
                if (r_ses != fwss_pkg::SES_CLOSED) begin
                    o_result.status = fwss_pkg::STS_WRONG;
                end else begin
                    n_erased  = '0;
                    n_ses     = fwss_pkg::SES_OPEN;
                    n_busy    = 1'b0;
                    n_written = 1'b0;
                end
            end
            fwss_pkg::KIND_WRITE: begin
                if (r_ses != fwss_pkg::SES_OPEN || r_busy) begin
                    o_result.status = fwss_pkg::STS_WRONG;
                end else if (w_bad_write) begin
                    n_ses           = fwss_pkg::SES_ERROR;
                    n_busy          = 1'b0;
                    o_result.status = fwss_pkg::STS_BOUNDS;
                end else begin
                    n_next     = i_item.address;
                    n_left     = i_item.length;
                    n_busy     = 1'b1;
                    w_do_issue = 1'b1;
                end
            end
            fwss_pkg::KIND_CLOSE: begin
                if (r_ses == fwss_pkg::SES_CLOSED) begin
                    o_result.status = fwss_pkg::STS_WRONG;
                end else begin
                    n_ses  = fwss_pkg::SES_CLOSED;
                    n_busy = 1'b0;
                    if (!(r_ses == fwss_pkg::SES_OPEN && !r_busy && r_written)) begin
                        o_result.status = fwss_pkg::STS_INCOMPLETE;
                    end
                end
            end
            default: begin
                if (!r_busy) begin
                    o_result.status = fwss_pkg::STS_WRONG;
                end else if (i_item.flash_result != fwss_pkg::FRES_OK) begin
                    n_ses  = fwss_pkg::SES_ERROR;
                    n_busy = 1'b0;
                    if (r_is_erase) begin
                        o_result.status = fwss_pkg::STS_ERASE_FAIL;
                    end else if (i_item.flash_result == fwss_pkg::FRES_VERIFY) begin
                        o_result.status = fwss_pkg::STS_VERIFY;
                    end else begin
                        o_result.status = fwss_pkg::STS_WRITE_FAIL;
                    end
                end else if (r_is_erase) begin
                    // The sector just erased is marked and its first chunk goes out now.
                    w_do_issue = 1'b1;
                    w_mark     = 1'b1;
                end else begin
                    n_next = w_next_adv;
                    n_left = w_left_adv;
                    if (w_left_adv == '0) begin
                        n_busy    = 1'b0;
                        n_written = 1'b1;
                    end else begin
                        w_do_issue = 1'b1;
                    end
                end
            end
        endcase

        w_sect_erased = r_erased[w_idx] || w_mark;
        if (w_do_issue) begin
            if (w_iss_fail) begin
                n_ses           = fwss_pkg::SES_ERROR;
                n_busy          = 1'b0;
                o_result.status = fwss_pkg::STS_BOUNDS;
            end else if (!w_sect_erased) begin
                n_is_erase = 1'b1;
                o_result.result_kind     = fwss_pkg::RK_ERASE;
                o_result.command_address = {w_cand_hi, fwss_pkg::SB_W'(0)};
            end else begin
                if (w_mark) begin
                    n_erased[w_idx] = 1'b1;
                end
                n_is_erase = 1'b0;
                n_chunk    = w_chunk;
                o_result.result_kind     = fwss_pkg::RK_PROGRAM;
                o_result.command_address = w_cand;
                o_result.command_length  = fwss_pkg::CLEN_W'(w_chunk);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_limit <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == fwss_pkg::CFG_REGION_BASE) begin
                r_base <= i_cfg_data;
            end else begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ses      <= fwss_pkg::SES_CLOSED;
            r_busy     <= 1'b0;
            r_is_erase <= 1'b0;
            r_next     <= '0;
            r_left     <= '0;
            r_chunk    <= '0;
            r_written  <= 1'b0;
            r_erased   <= '0;
        end else if (i_fire) begin
            r_ses      <= n_ses;
            r_busy     <= n_busy;
            r_is_erase <= n_is_erase;
            r_next     <= n_next;
            r_left     <= n_left;
            r_chunk    <= n_chunk;
            r_written  <= n_written;
            r_erased   <= n_erased;
        end
    end
endmodule

/* rtl/core/fwss_out_stage.sv */
// Result register stage: holds one result until the sink takes the transfer.
module fwss_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  fwss_pkg::t_result i_result,
    output logic              o_can_load,
    fwss_out_if.source        o_result
);
    logic              r_valid;
    fwss_pkg::t_result r_result;

    assign o_can_load = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_result.valid           = r_valid;
    assign o_result.result_kind     = r_result.result_kind;
    assign o_result.command_address = r_result.command_address;
    assign o_result.command_length  = r_result.command_length;
    assign o_result.status          = r_result.status;
endmodule

/* rtl/core/flash_write_session_sequencer_core.sv */
// Top level of the flash write session sequencer.
//
//   channel   direction  contents
//   i_item    in         kind, address, length, flash_result
//   o_result  out        result_kind, command_address, command_length, status
//   i_cfg_*   in         region_base (index 0), region_limit (index 1)
//
// Every item produces exactly one result: the item is held in the input register,
// and its result is held in the result register.
// A new item can be taken every cycle unless a result stalls; the session engine
// between the two registers handles each item combinationally.
// Reset clears the session to closed, the sector bitmap and both region registers.
// A stalled result holds the engine, and the input register then fills and drops ready.
module flash_write_session_sequencer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fwss_pkg::ADDR_W-1:0] i_cfg_data,
    fwss_in_if.sink                     i_item,
    fwss_out_if.source                  o_result
);
    logic              w_item_valid;
    fwss_pkg::t_item   w_item;
    fwss_pkg::t_result w_result;
    logic              w_can_load;
    logic              w_fire;

    assign w_fire = w_item_valid && w_can_load;

    fwss_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_advance (w_fire),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    fwss_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    fwss_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire),
        .i_result   (w_result),
        .o_can_load (w_can_load),
        .o_result   (o_result)
    );
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the flash write session sequencer.
module testbench;

    localparam logic [fwss_pkg::ADDR_W-1:0] SECT      = fwss_pkg::SECTOR_BYTES;
    localparam logic [fwss_pkg::ADDR_W-1:0] PAGE      = fwss_pkg::PAGE_BYTES;
    localparam logic [fwss_pkg::ADDR_W-1:0] DIR_BASE  = 32'h0001_0800;
    localparam logic [fwss_pkg::ADDR_W-1:0] DIR_LIMIT = 32'h000A_0000;
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 4000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    // One row of the directed table: either a register write or an item.
    typedef struct packed {
        logic                        cfg;
        logic                        typed;
        fwss_pkg::t_cfg_index        sel;
        fwss_pkg::t_kind             kind;
        logic [fwss_pkg::ADDR_W-1:0] address;
        logic [fwss_pkg::LEN_W-1:0]  length;
        fwss_pkg::t_fres             fres;
        fwss_pkg::t_status           want;
    } t_step;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic                        i_cfg_index;
    logic [fwss_pkg::ADDR_W-1:0] i_cfg_data;

    fwss_in_if  item_if();
    fwss_out_if result_if();

    flash_write_session_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // Session model kept alongside the block.
    fwss_pkg::t_session          ses_state = fwss_pkg::SES_CLOSED;
    logic                        wr_busy = 1'b0;
    logic                        wr_erasing = 1'b0;
    logic                        wr_any = 1'b0;
    logic [fwss_pkg::ADDR_W-1:0] wr_addr = '0;
    logic [fwss_pkg::LEN_W-1:0]  wr_left = '0;
    logic [fwss_pkg::CLEN_W-1:0] wr_chunk = '0;
    logic                        erased_map [fwss_pkg::MAX_SECTORS];
    logic [fwss_pkg::ADDR_W-1:0] rgn_base = '0;
    logic [fwss_pkg::ADDR_W-1:0] rgn_limit = '0;

    fwss_pkg::t_result pending_ops[$];
    t_step             plan[$];
    t_idle             idle_mode = IDLE_NONE;
    int                n_fail = 0;
    int                n_in = 0;
    int                n_out = 0;
    int                n_erase = 0;
    int                n_program = 0;
    int                stall_cycles = 0;
    int                resp_run = 0;

    initial foreach (erased_map[i]) erased_map[i] = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [fwss_pkg::ADDR_W-1:0] min32(
        input logic [fwss_pkg::ADDR_W-1:0] a, b);
        return (a < b) ? a : b;
    endfunction

    function automatic int unsigned idle_pct(input logic rx);
        case (idle_mode)
            IDLE_SEND: return rx ? 0 : 59;
            IDLE_RECV: return rx ? 59 : 0;
            IDLE_BOTH: return 7;
            default:   return 0;
        endcase
    endfunction

    function automatic fwss_pkg::t_result make_result(input fwss_pkg::t_rkind k,
                                                      input logic [fwss_pkg::ADDR_W-1:0] a,
                                                      input logic [fwss_pkg::CLEN_W-1:0] l,
                                                      input fwss_pkg::t_status s);
        return '{k, a, l, s};
    endfunction

    function automatic fwss_pkg::t_result abort_write(input fwss_pkg::t_status s);
        ses_state = fwss_pkg::SES_ERROR;
        wr_busy = 1'b0;
        return make_result(fwss_pkg::RK_STATUS, '0, '0, s);
    endfunction

    // Sector of the current address, counted from the region base aligned down.
    function automatic logic sector_slot(output int unsigned idx);
        logic [fwss_pkg::ADDR_W-1:0] sec, base_al;
        sec = wr_addr - wr_addr % SECT;
        base_al = rgn_base - rgn_base % SECT;
        idx = (sec - base_al) / SECT;
        return sec >= base_al && idx < fwss_pkg::MAX_SECTORS;
    endfunction

    function automatic fwss_pkg::t_result next_command();
        int unsigned idx;
        logic [fwss_pkg::ADDR_W-1:0] room;
        if (!sector_slot(idx)) return abort_write(fwss_pkg::STS_BOUNDS);
        if (!erased_map[idx]) begin
            wr_erasing = 1'b1;
            return make_result(fwss_pkg::RK_ERASE, wr_addr - wr_addr % SECT, '0,
                               fwss_pkg::STS_OK);
        end
        // A program chunk never crosses a page boundary.
        room = PAGE - wr_addr % PAGE;
        if (room > 32'(wr_left)) room = 32'(wr_left);
        wr_chunk = room[fwss_pkg::CLEN_W-1:0];
        wr_erasing = 1'b0;
        return make_result(fwss_pkg::RK_PROGRAM, wr_addr, wr_chunk, fwss_pkg::STS_OK);
    endfunction

    function automatic fwss_pkg::t_result session_step(input fwss_pkg::t_item it);
        logic ok;
        int unsigned idx;
        case (it.kind)
            fwss_pkg::KIND_OPEN: begin
                if (ses_state != fwss_pkg::SES_CLOSED)
                    return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_WRONG);
                foreach (erased_map[i]) erased_map[i] = 1'b0;
                ses_state = fwss_pkg::SES_OPEN;
                wr_busy = 1'b0;
                wr_any = 1'b0;
                return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_OK);
            end
            fwss_pkg::KIND_WRITE: begin
                if (ses_state != fwss_pkg::SES_OPEN || wr_busy)
                    return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_WRONG);
                if (it.length == '0 || it.address < rgn_base || it.address >= rgn_limit ||
                    32'(it.length) > rgn_limit - it.address)
                    return abort_write(fwss_pkg::STS_BOUNDS);
                wr_addr = it.address;
                wr_left = it.length;
                wr_busy = 1'b1;
                return next_command();
            end
            fwss_pkg::KIND_CLOSE: begin
                if (ses_state == fwss_pkg::SES_CLOSED)
                    return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_WRONG);
                ok = ses_state == fwss_pkg::SES_OPEN && !wr_busy && wr_any;
                ses_state = fwss_pkg::SES_CLOSED;
                wr_busy = 1'b0;
                return make_result(fwss_pkg::RK_STATUS, '0, '0,
                                   ok ? fwss_pkg::STS_OK : fwss_pkg::STS_INCOMPLETE);
            end
            default: begin
                if (!wr_busy)
                    return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_WRONG);
                if (it.flash_result != fwss_pkg::FRES_OK) begin
                    if (wr_erasing) return abort_write(fwss_pkg::STS_ERASE_FAIL);
                    return abort_write(it.flash_result == fwss_pkg::FRES_VERIFY
                                       ? fwss_pkg::STS_VERIFY : fwss_pkg::STS_WRITE_FAIL);
                end
                if (wr_erasing) begin
                    if (!sector_slot(idx)) return abort_write(fwss_pkg::STS_BOUNDS);
                    erased_map[idx] = 1'b1;
                    return next_command();
                end
                wr_addr += 32'(wr_chunk);
                wr_left -= 24'(wr_chunk);
                if (wr_left == '0) begin
                    wr_busy = 1'b0;
                    wr_any = 1'b1;
                    return make_result(fwss_pkg::RK_STATUS, '0, '0, fwss_pkg::STS_OK);
                end
                return next_command();
            end
        endcase
    endfunction

    // Mostly well-formed sessions: open, writes answered by flash responses, close.
    function automatic fwss_pkg::t_item pick_item();
        fwss_pkg::t_item it;
        int unsigned r;
        logic [fwss_pkg::ADDR_W-1:0] span, off, room, cap;
        it.kind = fwss_pkg::KIND_RESP;
        it.address = $urandom;
        it.length = 24'($urandom);
        it.flash_result = fwss_pkg::FRES_OK;
        r = $urandom_range(99);
        resp_run = wr_busy ? resp_run + 1 : 0;
        if (r < 4) begin
            it.kind = 2'($urandom);
            it.flash_result = 2'($urandom);
            return it;
        end
        if (wr_busy) begin
            // Long writes are cut short by a close so that a session never drags on.
            if (resp_run > 12 || r < 7) it.kind = fwss_pkg::KIND_CLOSE;
            else if (r < 12) it.flash_result = 2'($urandom_range(3, 1));
            return it;
        end
        if (ses_state == fwss_pkg::SES_CLOSED) begin
            it.kind = fwss_pkg::KIND_OPEN;
            return it;
        end
        if ((ses_state == fwss_pkg::SES_ERROR) ? (r < 85) : (r < 15)) begin
            it.kind = fwss_pkg::KIND_CLOSE;
            return it;
        end
        it.kind = fwss_pkg::KIND_WRITE;
        span = (rgn_limit > rgn_base) ? rgn_limit - rgn_base : '0;
        r = $urandom_range(99);
        if (span == '0 || r < 14) begin
            case (r % 4)
                0: begin
                    it.address = rgn_base;
                    it.length = '0;
                end
                1: it.address = rgn_base - 32'($urandom_range(1, 64));
                2: it.address = rgn_limit + 32'($urandom_range(0, 64));
                default: begin
                    it.address = rgn_limit - 32'($urandom_range(1, 64));
                    it.length = 24'(rgn_limit - it.address + 1);
                end
            endcase
            return it;
        end
        if (r < 50) off = $urandom_range(0, min32(span - 1, 2 * SECT));
        else if (r < 65) off = $urandom_range(0, min32(span - 1, 130 * SECT));
        else if (r < 82) off = $urandom % span;
        else off = span - 1 - $urandom_range(0, min32(span - 1, 700));
        it.address = rgn_base + off;
        room = rgn_limit - it.address;
        cap = ($urandom_range(19) == 0) ? 32'h00FF_FFFF : 32'd700;
        it.length = 24'($urandom_range(1, min32(room, cap)));
        return it;
    endfunction

    task automatic send_item(input fwss_pkg::t_item it, input logic typed,
                             input fwss_pkg::t_status want);
        fwss_pkg::t_result pred;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct(1'b0)) begin
            item_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.kind <= it.kind;
        item_if.address <= it.address;
        item_if.length <= it.length;
        item_if.flash_result <= it.flash_result;
        do @(posedge i_clk); while (!item_if.ready);
        n_in++;
        pred = session_step(it);
        pending_ops.push_back(typed ? make_result(fwss_pkg::RK_STATUS, '0, '0, want) : pred);
    endtask

    // Let every expected result come out, then let the pipeline settle.
    task automatic drain();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_ops.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input fwss_pkg::t_cfg_index sel,
                             input logic [fwss_pkg::ADDR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == fwss_pkg::CFG_REGION_BASE) rgn_base = data;
        else rgn_limit = data;
    endtask

    task automatic run_phase(input logic [fwss_pkg::ADDR_W-1:0] b, l, input t_idle mode,
                             input int n);
        drain();
        cfg_write(fwss_pkg::CFG_REGION_BASE, b);
        cfg_write(fwss_pkg::CFG_REGION_LIMIT, l);
        idle_mode = mode;
        repeat (n) send_item(pick_item(), 1'b0, fwss_pkg::STS_OK);
    endtask

    task automatic add(input fwss_pkg::t_kind k, input logic [fwss_pkg::ADDR_W-1:0] a,
                       input logic [fwss_pkg::LEN_W-1:0] len, input fwss_pkg::t_fres f,
                       input logic typed, input fwss_pkg::t_status w);
        plan.push_back('{1'b0, typed, fwss_pkg::CFG_REGION_BASE, k, a, len, f, w});
    endtask

    task automatic add_cfg(input fwss_pkg::t_cfg_index s, input logic [fwss_pkg::ADDR_W-1:0] d);
        plan.push_back('{1'b1, 1'b0, s, fwss_pkg::KIND_OPEN, d, '0, fwss_pkg::FRES_OK,
                         fwss_pkg::STS_OK});
    endtask

    task automatic check_field(input string name, input logic [fwss_pkg::ADDR_W-1:0] want, got);
        if (got !== want) begin
            n_fail++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(negedge i_clk) result_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));

    always @(posedge i_clk) begin
        fwss_pkg::t_result want;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                n_out++;
                if (result_if.result_kind == fwss_pkg::RK_ERASE) n_erase++;
                if (result_if.result_kind == fwss_pkg::RK_PROGRAM) n_program++;
                if (pending_ops.size() == 0) begin
                    n_fail++;
                    $display("%0t: result with nothing expected, kind %0d addr %0h status %0d",
                             $time, result_if.result_kind, result_if.command_address,
                             result_if.status);
                end else begin
                    want = pending_ops.pop_front();
                    check_field("result_kind", 32'(want.result_kind), 32'(result_if.result_kind));
                    check_field("command_address", want.command_address,
                                result_if.command_address);
                    check_field("command_length", 32'(want.command_length),
                                32'(result_if.command_length));
                    check_field("status", 32'(want.status), 32'(result_if.status));
                end
            end
            if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still due",
                         $time, stall_cycles, pending_ops.size());
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin
        logic [fwss_pkg::ADDR_W-1:0] b, l;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = fwss_pkg::CFG_REGION_BASE;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.kind = fwss_pkg::KIND_OPEN;
        item_if.address = '0;
        item_if.length = '0;
        item_if.flash_result = fwss_pkg::FRES_OK;
        result_if.ready = 1'b0;

        // Region registers are zero after reset, so every write is out of bounds here.
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_WRITE, DIR_BASE, 24'd16, fwss_pkg::FRES_OK, 1'b1,
            fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_WRITE, 32'hFFFF_FFFF, 24'hFF_FFFF, fwss_pkg::FRES_VERIFY, 1'b1,
            fwss_pkg::STS_BOUNDS);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_INCOMPLETE);
        add_cfg(fwss_pkg::CFG_REGION_BASE, DIR_BASE);
        add_cfg(fwss_pkg::CFG_REGION_LIMIT, DIR_LIMIT);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_WRITE, DIR_BASE, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_BOUNDS);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_INCOMPLETE);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_WRITE, 32'h0009_FF00, 24'h101, fwss_pkg::FRES_OK, 1'b1,
            fwss_pkg::STS_BOUNDS);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_INCOMPLETE);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        // Erase, then two chunks split at a page boundary.
        add(fwss_pkg::KIND_WRITE, 32'h0001_09F0, 24'h20, fwss_pkg::FRES_OK, 1'b0,
            fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_WRITE, DIR_BASE, 24'd1, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b0, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b0, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_WRONG);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_WRITE, DIR_BASE, 24'd1, fwss_pkg::FRES_OK, 1'b0, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_OK, 1'b0, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_VERIFY, 1'b1, fwss_pkg::STS_VERIFY);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_INCOMPLETE);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        // The first sector past the bitmap, although still inside the region.
        add(fwss_pkg::KIND_WRITE, 32'h0009_0000, 24'd1, fwss_pkg::FRES_OK, 1'b1,
            fwss_pkg::STS_BOUNDS);
        add(fwss_pkg::KIND_CLOSE, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_INCOMPLETE);
        add(fwss_pkg::KIND_OPEN, '0, '0, fwss_pkg::FRES_OK, 1'b1, fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_WRITE, 32'h0008_F000, 24'h1000, fwss_pkg::FRES_OK, 1'b0,
            fwss_pkg::STS_OK);
        add(fwss_pkg::KIND_RESP, '0, '0, fwss_pkg::FRES_FAIL, 1'b1, fwss_pkg::STS_ERASE_FAIL);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg) begin
                drain();
                cfg_write(plan[i].sel, plan[i].address);
            end else begin
                send_item('{plan[i].kind, plan[i].address, plan[i].length, plan[i].fres},
                          plan[i].typed, plan[i].want);
            end
        end

        run_phase(32'h0000_0000, 32'hFFFF_FFFF, IDLE_NONE, 112);
        run_phase(32'h0123_4567, 32'h0125_0000, IDLE_SEND, 112);
        run_phase(32'h2000_0000, 32'h2009_0000, IDLE_RECV, 112);
        run_phase(32'hFFFF_F000, 32'hFFFF_FFFF, IDLE_BOTH, 112);
        b = $urandom;
        l = b + $urandom_range(fwss_pkg::SECTOR_BYTES, 200 * fwss_pkg::SECTOR_BYTES);
        if (l < b) l = 32'hFFFF_FFFF;
        run_phase(b, l, IDLE_NONE, 112);
        run_phase(32'hFFFF_FFFF, 32'h0000_0000, IDLE_SEND, 40);
        drain();

        $display("%0d items accepted, %0d results checked (%0d erase, %0d program commands),",
                 n_in, n_out, n_erase, n_program);
        $display("over six region settings and four patterns of idling and stalls.");
        if (n_fail == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule
